>>> hw/rtl/barycentric_clamp_renormalize_assert.svh
// Assertion macros for the barycentric clamp and renormalize block.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef BARYCENTRIC_CLAMP_RENORMALIZE_ASSERT_SVH
`define BARYCENTRIC_CLAMP_RENORMALIZE_ASSERT_SVH

`ifndef ASSERT_OFF
`define BCR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define BCR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`else
`define BCR_ASSERT(lbl, prop, msg)
`define BCR_ASSERT_IMP(lbl, ante, cons, msg)
`endif

`endif

>>> hw/rtl/bcr_pkg.sv
// Shared constants, types and stage payloads of the barycentric clamp block.
// No dependencies.
package bcr_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int IN_W       = 20;
  localparam int OUT_W      = 17;
  localparam int EPS_W      = 15;
  localparam int WIDE_W     = IN_W + 2;
  localparam int VAL_W      = FRAC_BITS + 1;
  localparam int DIFF_W     = VAL_W + 3;
  localparam int SUM_W      = VAL_W + 2;
  localparam int DATA_W     = 32;
  localparam int ADDR_W     = 3;
  localparam int DIV_SPS    = 4;
  localparam int DIV_STAGES = (FRAC_BITS + DIV_SPS - 1) / DIV_SPS;
  localparam int ONE_INT    = 1 << FRAC_BITS;

  localparam logic [EPS_W-1:0] EPS_MAX   = EPS_W'(ONE_INT / 3);
  localparam logic [EPS_W-1:0] EPS_MIN   = EPS_W'(1);
  localparam logic [EPS_W-1:0] EPS_RESET = EPS_W'(66);

  typedef enum logic [0:0] {
    REG_EPS
  } reg_e;

  typedef enum logic [1:0] {
    SLOT_MIN,
    SLOT_MID,
    SLOT_MAX
  } slot_e;

  typedef logic signed [WIDE_W-1:0] wide_t;
  typedef logic [VAL_W-1:0]         val_t;

  typedef struct packed {
    slot_e alpha;
    slot_e beta;
    slot_e gamma;
  } rank_t;

  typedef struct packed {
    wide_t v_alpha;
    wide_t v_beta;
    wide_t v_gamma;
    rank_t rank;
  } sorted_t;

  typedef struct packed {
    val_t  v_min;
    val_t  v_mid;
    val_t  v_max;
    val_t  sum;
    rank_t rank;
  } norm_t;

endpackage

>>> hw/rtl/barycentric_clamp_renormalize.sv
// Channel      Handshake                         Payload
// in           in_valid_i / in_ready_o           alpha_in_i, beta_in_i
// out          out_valid_o / out_ready_i         alpha_out_o, beta_out_o, gamma_out_o
// config       psel, penable, pwrite / pready    paddr, pwdata, prdata
// One item enters per cycle while the output is not stalled; there are two ranking stages, four clamp and
// sum stages, and four divider stages of four quotient bits each in three lanes.
// Every stage advances when it is empty or its successor advances, so a stall at the
// output fills the bubbles before input ready drops.
// Reset clears all valid bits and sets eps to 66.
// Top level; depends on bcr_pkg, bcr_cfg, bcr_sort, bcr_clamp, bcr_div.
`include "barycentric_clamp_renormalize_assert.svh"
module barycentric_clamp_renormalize import bcr_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [ADDR_W-1:0]      paddr,
  input  logic [DATA_W-1:0]      pwdata,
  output logic [DATA_W-1:0]      prdata,
  output logic                   pready,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic signed [IN_W-1:0] alpha_in_i,
  input  logic signed [IN_W-1:0] beta_in_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [OUT_W-1:0]       alpha_out_o,
  output logic [OUT_W-1:0]       beta_out_o,
  output logic [OUT_W-1:0]       gamma_out_o
);

  logic [EPS_W-1:0] eps;
  sorted_t          sorted;
  logic             sorted_valid, sorted_ready;
  norm_t            norm;
  logic             norm_valid, norm_ready;
  logic [OUT_W+1:0] out_sum;
  logic             sum_ok;

  bcr_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .eps_o   (eps)
  );

  bcr_sort u_sort (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .alpha_in_i  (alpha_in_i),
    .beta_in_i   (beta_in_i),
    .out_valid_o (sorted_valid),
    .out_ready_i (sorted_ready),
    .out_o       (sorted)
  );

  bcr_clamp u_clamp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .eps_i       (eps),
    .in_valid_i  (sorted_valid),
    .in_ready_o  (sorted_ready),
    .in_i        (sorted),
    .out_valid_o (norm_valid),
    .out_ready_i (norm_ready),
    .out_o       (norm)
  );

  bcr_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (norm_valid),
    .in_ready_o  (norm_ready),
    .in_i        (norm),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .alpha_out_o (alpha_out_o),
    .beta_out_o  (beta_out_o),
    .gamma_out_o (gamma_out_o)
  );

  assign out_sum = (OUT_W+2)'(alpha_out_o) + (OUT_W+2)'(beta_out_o) + (OUT_W+2)'(gamma_out_o);
  assign sum_ok  = (out_sum <= (OUT_W+2)'(ONE_INT)) && (out_sum + 2 >= (OUT_W+2)'(ONE_INT));

  `BCR_ASSERT_IMP(a_out_sum, out_valid_o, sum_ok, "output coordinates do not sum to one")
  `BCR_ASSERT(a_eps_range, (eps >= EPS_MIN) && (eps <= EPS_MAX), "working eps out of range")

endmodule

>>> hw/rtl/bcr_cfg.sv
// Configuration register file: eps register and its saturated working value.
// Depends on bcr_pkg.
module bcr_cfg import bcr_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output logic [EPS_W-1:0]  eps_o
);

  logic [EPS_W-1:0] eps_q, eps_d;
  logic [EPS_W-1:0] eps_eff_q, eps_eff_d;
  logic             wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & (paddr[ADDR_W-1:2] == REG_EPS);
  assign eps_d  = pwdata[EPS_W-1:0];
  assign eps_o  = eps_eff_q;

  always_comb begin
    if (eps_d == '0) begin
      eps_eff_d = EPS_MIN;
    end else if (32'(eps_d) > ONE_INT / 3) begin
      eps_eff_d = EPS_MAX;
    end else begin
      eps_eff_d = eps_d;
    end
  end

  always_comb begin
    case (paddr[ADDR_W-1:2])
      REG_EPS: begin
        prdata = DATA_W'(eps_q);
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eps_q     <= EPS_RESET;
      eps_eff_q <= EPS_RESET;
    end else if (wr_en) begin
      eps_q     <= eps_d;
      eps_eff_q <= eps_eff_d;
    end
  end

endmodule

>>> hw/rtl/bcr_sort.sv
// Front stages: form gamma, then rank the three coordinates with stable ties.
// Depends on bcr_pkg and the assertion macro header.
`include "barycentric_clamp_renormalize_assert.svh"
module bcr_sort import bcr_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic signed [IN_W-1:0] alpha_in_i,
  input  logic signed [IN_W-1:0] beta_in_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output sorted_t                out_o
);

  logic [1:0] vld_q;
  logic [2:0] rdy;
  wide_t      a_q, a_d, b_q, b_d, g_q, g_d;
  sorted_t    s_q, s_d;
  logic       lt_ba, lt_ga, lt_gb;
  logic       rank_ok;

  always_comb begin
    rdy[2] = out_ready_i;
    rdy[1] = !vld_q[1] || rdy[2];
    rdy[0] = !vld_q[0] || rdy[1];
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = vld_q[1];
  assign out_o       = s_q;

  always_comb begin
    a_d = wide_t'(alpha_in_i);
    b_d = wide_t'(beta_in_i);
    g_d = wide_t'(ONE_INT) - a_d - b_d;
  end

  always_comb begin
    lt_ba          = b_q < a_q;
    lt_ga          = g_q < a_q;
    lt_gb          = g_q < b_q;
    s_d.v_alpha    = a_q;
    s_d.v_beta     = b_q;
    s_d.v_gamma    = g_q;
    s_d.rank.alpha = slot_e'(2'(lt_ba) + 2'(lt_ga));
    s_d.rank.beta  = slot_e'(2'(!lt_ba) + 2'(lt_gb));
    s_d.rank.gamma = slot_e'(2'(!lt_ga) + 2'(!lt_gb));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) begin
        vld_q[0] <= in_valid_i;
      end
      if (rdy[1]) begin
        vld_q[1] <= vld_q[0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0] && in_valid_i) begin
      a_q <= a_d;
      b_q <= b_d;
      g_q <= g_d;
    end
    if (rdy[1] && vld_q[0]) begin
      s_q <= s_d;
    end
  end

  assign rank_ok = (s_q.rank.alpha != s_q.rank.beta) && (s_q.rank.alpha != s_q.rank.gamma)
                && (s_q.rank.beta != s_q.rank.gamma);

  `BCR_ASSERT_IMP(a_rank_perm, vld_q[1], rank_ok, "ranks do not form a permutation")

endmodule

>>> hw/rtl/bcr_clamp.sv
// Middle stages: clamp smallest and largest, rebalance the middle, form the sum.
// Depends on bcr_pkg and the assertion macro header.
`include "barycentric_clamp_renormalize_assert.svh"
module bcr_clamp import bcr_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [EPS_W-1:0] eps_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  sorted_t          in_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output norm_t            out_o
);

  typedef logic signed [DIFF_W-1:0] diff_t;

  logic [3:0] vld_q;
  logic [4:0] rdy;

  wide_t e_w, ome_w, mn, mx, c_min, c_max;
  val_t  v0_q, v0_d, v2_q, v2_d;
  rank_t rk3_q, rk4_q, rk5_q;

  diff_t e_s, ome_s;
  diff_t m0_q, m0_d, m1_q, m1_d, m2_q, m2_d, cand0_q, cand0_d, cand2_q, cand2_d;
  logic  lo_q, lo_d, hi_q, hi_d;

  diff_t r0, r1, r2;
  val_t  n0_q, n0_d, n1_q, n1_d, n2_q, n2_d;

  logic [SUM_W-1:0] sum_full;
  norm_t            o_q, o_d;
  logic             norm_ok;

  function automatic wide_t pick_v(sorted_t s, slot_e k);
    if (s.rank.alpha == k) begin
      return s.v_alpha;
    end else if (s.rank.beta == k) begin
      return s.v_beta;
    end
    return s.v_gamma;
  endfunction

  always_comb begin
    rdy[4] = out_ready_i;
    for (int k = 3; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = vld_q[3];
  assign out_o       = o_q;

  // clamp smallest up and largest down
  always_comb begin
    e_w   = wide_t'(eps_i);
    ome_w = wide_t'(ONE_INT) - e_w;
    mn    = pick_v(in_i, SLOT_MIN);
    mx    = pick_v(in_i, SLOT_MAX);
    c_min = (mn < e_w) ? e_w : mn;
    c_max = (mx > ome_w) ? ome_w : mx;
    v0_d  = c_min[VAL_W-1:0];
    v2_d  = c_max[VAL_W-1:0];
  end

  // middle remainder and the candidates for rebalancing
  always_comb begin
    e_s     = diff_t'(eps_i);
    ome_s   = diff_t'(ONE_INT) - e_s;
    m0_d    = diff_t'(v0_q);
    m2_d    = diff_t'(v2_q);
    m1_d    = diff_t'(ONE_INT) - m0_d - m2_d;
    lo_d    = m1_d < e_s;
    hi_d    = m1_d > ome_s;
    cand2_d = diff_t'(ONE_INT) - m0_d - e_s;
    cand0_d = m0_d + m0_d + m2_d - e_s;
  end

  always_comb begin
    r0 = m0_q;
    r1 = m1_q;
    r2 = m2_q;
    if (lo_q) begin
      r1 = e_s;
      r2 = (cand2_q < e_s) ? e_s : cand2_q;
    end else if (hi_q) begin
      r1 = ome_s;
      r0 = (cand0_q < e_s) ? e_s : cand0_q;
    end
    n0_d = r0[VAL_W-1:0];
    n1_d = r1[VAL_W-1:0];
    n2_d = r2[VAL_W-1:0];
  end

  always_comb begin
    sum_full   = SUM_W'(n0_q) + SUM_W'(n1_q) + SUM_W'(n2_q);
    o_d.v_min  = n0_q;
    o_d.v_mid  = n1_q;
    o_d.v_max  = n2_q;
    o_d.sum    = sum_full[VAL_W-1:0];
    o_d.rank   = rk5_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) begin
        vld_q[0] <= in_valid_i;
      end
      for (int k = 1; k < 4; k++) begin
        if (rdy[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0] && in_valid_i) begin
      v0_q  <= v0_d;
      v2_q  <= v2_d;
      rk3_q <= in_i.rank;
    end
    if (rdy[1] && vld_q[0]) begin
      m0_q    <= m0_d;
      m1_q    <= m1_d;
      m2_q    <= m2_d;
      cand0_q <= cand0_d;
      cand2_q <= cand2_d;
      lo_q    <= lo_d;
      hi_q    <= hi_d;
      rk4_q   <= rk3_q;
    end
    if (rdy[2] && vld_q[1]) begin
      n0_q  <= n0_d;
      n1_q  <= n1_d;
      n2_q  <= n2_d;
      rk5_q <= rk4_q;
    end
    if (rdy[3] && vld_q[2]) begin
      o_q <= o_d;
    end
  end

  assign norm_ok = (o_q.v_min != '0) && (o_q.v_mid != '0) && (o_q.v_max != '0)
                && (o_q.sum <= val_t'(ONE_INT)) && (o_q.v_max < o_q.sum);

  `BCR_ASSERT_IMP(a_norm_bounds, vld_q[3], norm_ok, "normalized values out of bounds")

endmodule

>>> hw/rtl/bcr_div.sv
// Pipelined restoring divider, three lanes, then reorder to alpha, beta, gamma.
// Depends on bcr_pkg and the assertion macro header.
`include "barycentric_clamp_renormalize_assert.svh"
module bcr_div import bcr_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  norm_t            in_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [OUT_W-1:0] alpha_out_o,
  output logic [OUT_W-1:0] beta_out_o,
  output logic [OUT_W-1:0] gamma_out_o
);

  typedef struct packed {
    val_t                 rem;
    logic [FRAC_BITS-1:0] quo;
  } divst_t;

  localparam int Last = DIV_STAGES - 1;

  logic [DIV_STAGES-1:0] vld_q, vin;
  logic [DIV_STAGES:0]   rdy;
  divst_t st_in [DIV_STAGES][3];
  divst_t st_d  [DIV_STAGES][3];
  divst_t st_q  [DIV_STAGES][3];
  val_t   dv_in [DIV_STAGES];
  val_t   dv_q  [DIV_STAGES];
  rank_t  rk_in [DIV_STAGES];
  rank_t  rk_q  [DIV_STAGES];
  logic   rem_ok;

  function automatic divst_t div_chunk(divst_t st, val_t d, int stage);
    logic [VAL_W:0] t;
    divst_t         res;
    res = st;
    for (int i = 0; i < DIV_SPS; i++) begin
      if (stage * DIV_SPS + i < FRAC_BITS) begin
        t = {res.rem, 1'b0};
        if (t >= {1'b0, d}) begin
          t       = t - {1'b0, d};
          res.quo = {res.quo[FRAC_BITS-2:0], 1'b1};
        end else begin
          res.quo = {res.quo[FRAC_BITS-2:0], 1'b0};
        end
        res.rem = t[VAL_W-1:0];
      end
    end
    return res;
  endfunction

  function automatic logic [FRAC_BITS-1:0] pick_q(slot_e k, logic [FRAC_BITS-1:0] q0,
                                                  logic [FRAC_BITS-1:0] q1,
                                                  logic [FRAC_BITS-1:0] q2);
    case (k)
      SLOT_MIN: return q0;
      SLOT_MID: return q1;
      SLOT_MAX: return q2;
      default:  return '0;
    endcase
  endfunction

  always_comb begin
    rdy[DIV_STAGES] = out_ready_i;
    for (int k = DIV_STAGES - 1; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = vld_q[Last];

  always_comb begin
    vin[0]      = in_valid_i;
    st_in[0][0] = '{rem: in_i.v_min, quo: '0};
    st_in[0][1] = '{rem: in_i.v_mid, quo: '0};
    st_in[0][2] = '{rem: in_i.v_max, quo: '0};
    dv_in[0]    = in_i.sum;
    rk_in[0]    = in_i.rank;
    for (int k = 1; k < DIV_STAGES; k++) begin
      vin[k]   = vld_q[k-1];
      st_in[k] = st_q[k-1];
      dv_in[k] = dv_q[k-1];
      rk_in[k] = rk_q[k-1];
    end
    for (int k = 0; k < DIV_STAGES; k++) begin
      for (int l = 0; l < 3; l++) begin
        st_d[k][l] = div_chunk(st_in[k][l], dv_in[k], k);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < DIV_STAGES; k++) begin
        if (rdy[k]) begin
          vld_q[k] <= vin[k];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < DIV_STAGES; k++) begin
      if (rdy[k] && vin[k]) begin
        st_q[k] <= st_d[k];
        dv_q[k] <= dv_in[k];
        rk_q[k] <= rk_in[k];
      end
    end
  end

  assign alpha_out_o = OUT_W'(pick_q(rk_q[Last].alpha, st_q[Last][0].quo, st_q[Last][1].quo,
                                     st_q[Last][2].quo));
  assign beta_out_o  = OUT_W'(pick_q(rk_q[Last].beta, st_q[Last][0].quo, st_q[Last][1].quo,
                                     st_q[Last][2].quo));
  assign gamma_out_o = OUT_W'(pick_q(rk_q[Last].gamma, st_q[Last][0].quo, st_q[Last][1].quo,
                                     st_q[Last][2].quo));

  assign rem_ok = (st_q[0][0].rem < dv_q[0]) && (st_q[0][1].rem < dv_q[0])
               && (st_q[0][2].rem < dv_q[0]);

  `BCR_ASSERT_IMP(a_rem_below_div, vld_q[0], rem_ok, "remainder not below divisor")

endmodule

>>> tb/sv/bcr_weight_checker.sv
`timescale 1ns / 1ps
// Result checker for barycentric_clamp_renormalize: follows eps through APB writes,
// predicts the clamped and renormalized weights of each item and compares them in order.
// Depends on bcr_pkg.
module bcr_weight_checker import bcr_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   psel_i,
  input  logic                   penable_i,
  input  logic                   pwrite_i,
  input  logic                   pready_i,
  input  logic [ADDR_W-1:0]      paddr_i,
  input  logic [DATA_W-1:0]      pwdata_i,
  input  logic                   in_valid_i,
  input  logic                   in_ready_i,
  input  logic signed [IN_W-1:0] alpha_in_i,
  input  logic signed [IN_W-1:0] beta_in_i,
  input  logic                   out_valid_i,
  input  logic                   out_ready_i,
  input  logic [OUT_W-1:0]       alpha_out_i,
  input  logic [OUT_W-1:0]       beta_out_i,
  input  logic [OUT_W-1:0]       gamma_out_i,
  output int                     pending_o,
  output int                     fails_o
);

  localparam logic [ADDR_W-1:0] EPS_ADDR = ADDR_W'(4 * int'(REG_EPS));

  typedef struct packed {
    logic [OUT_W-1:0] alpha;
    logic [OUT_W-1:0] beta;
    logic [OUT_W-1:0] gamma;
  } weights_t;

  weights_t         weights_q[$];
  logic [EPS_W-1:0] eps_q;
  int               fail_cnt;

  function automatic weights_t clamp_weights(input logic signed [IN_W-1:0] a,
                                             input logic signed [IN_W-1:0] b,
                                             input logic [EPS_W-1:0] eps_raw);
    longint           val[3];
    int               slot[3];
    longint           lim;
    longint           key;
    longint           gap;
    longint           total;
    int               key_slot;
    int               j;
    logic [OUT_W-1:0] res[3];
    lim = longint'(eps_raw);
    if (lim < 1) lim = 1;
    if (lim > ONE_INT / 3) lim = ONE_INT / 3;
    val[0] = a;
    val[1] = b;
    val[2] = ONE_INT - val[0] - val[1];
    for (int i = 0; i < 3; i++) slot[i] = i;
    for (int i = 1; i < 3; i++) begin
      key = val[i];
      key_slot = slot[i];
      j = i - 1;
      while (j >= 0 && key < val[j]) begin
        val[j+1] = val[j];
        slot[j+1] = slot[j];
        j--;
      end
      val[j+1] = key;
      slot[j+1] = key_slot;
    end
    if (val[0] < lim) val[0] = lim;
    if (val[2] > ONE_INT - lim) val[2] = ONE_INT - lim;
    val[1] = ONE_INT - val[0] - val[2];
    if (val[1] < lim) begin
      gap = lim - val[1];
      val[1] = lim;
      val[2] -= gap;
      if (val[2] < lim) val[2] = lim;
    end else if (val[1] > ONE_INT - lim) begin
      gap = val[1] - (ONE_INT - lim);
      val[1] = ONE_INT - lim;
      val[0] -= gap;
      if (val[0] < lim) val[0] = lim;
    end
    total = val[0] + val[1] + val[2];
    for (int i = 0; i < 3; i++) res[slot[i]] = OUT_W'((val[i] * ONE_INT) / total);
    return '{alpha: res[0], beta: res[1], gamma: res[2]};
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    weights_t want;
    if (!rst_ni) begin
      eps_q = EPS_RESET;
      weights_q.delete();
      fail_cnt = 0;
      pending_o <= 0;
      fails_o <= 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i && paddr_i == EPS_ADDR) begin
        eps_q = pwdata_i[EPS_W-1:0];
      end
      if (in_valid_i && in_ready_i) begin
        weights_q.push_back(clamp_weights(alpha_in_i, beta_in_i, eps_q));
      end
      if (out_valid_i && out_ready_i) begin
        if (weights_q.size() == 0) begin
          $error("result with no item pending");
          fail_cnt++;
        end else begin
          want = weights_q.pop_front();
          if (alpha_out_i !== want.alpha) begin
            $error("alpha_out: expected %0d, got %0d", want.alpha, alpha_out_i);
            fail_cnt++;
          end
          if (beta_out_i !== want.beta) begin
            $error("beta_out: expected %0d, got %0d", want.beta, beta_out_i);
            fail_cnt++;
          end
          if (gamma_out_i !== want.gamma) begin
            $error("gamma_out: expected %0d, got %0d", want.gamma, gamma_out_i);
            fail_cnt++;
          end
        end
      end
      pending_o <= weights_q.size();
      fails_o <= fail_cnt;
    end
  end

endmodule

>>> tb/sv/barycentric_clamp_renormalize_tb.sv
`timescale 1ns / 1ps
// Top testbench for barycentric_clamp_renormalize: drives items, eps writes and output
// stalls, and gives the verdict. Depends on bcr_pkg, bcr_weight_checker and the block.
module barycentric_clamp_renormalize_tb;
  import bcr_pkg::*;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int PHASE_ITEMS  = 119;
  localparam logic [ADDR_W-1:0] EPS_ADDR = ADDR_W'(4 * int'(REG_EPS));

  logic                   clk_i     = 1'b0;
  logic                   rst_ni    = 1'b0;
  logic                   psel      = 1'b0;
  logic                   penable   = 1'b0;
  logic                   pwrite    = 1'b0;
  logic [ADDR_W-1:0]      paddr     = '0;
  logic [DATA_W-1:0]      pwdata    = '0;
  logic [DATA_W-1:0]      prdata;
  logic                   pready;
  logic                   in_valid  = 1'b0;
  logic                   in_ready;
  logic signed [IN_W-1:0] alpha_in  = '0;
  logic signed [IN_W-1:0] beta_in   = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [OUT_W-1:0]       alpha_out;
  logic [OUT_W-1:0]       beta_out;
  logic [OUT_W-1:0]       gamma_out;
  int                     pending;
  int                     fails;
  int                     cycles     = 0;
  int                     stall_left = 0;
  logic                   quiet      = 1'b0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  barycentric_clamp_renormalize u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .alpha_in_i (alpha_in),
    .beta_in_i  (beta_in),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .alpha_out_o(alpha_out),
    .beta_out_o (beta_out),
    .gamma_out_o(gamma_out)
  );

  bcr_weight_checker u_weight_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel_i     (psel),
    .penable_i  (penable),
    .pwrite_i   (pwrite),
    .pready_i   (pready),
    .paddr_i    (paddr),
    .pwdata_i   (pwdata),
    .in_valid_i (in_valid),
    .in_ready_i (in_ready),
    .alpha_in_i (alpha_in),
    .beta_in_i  (beta_in),
    .out_valid_i(out_valid),
    .out_ready_i(out_ready),
    .alpha_out_i(alpha_out),
    .beta_out_i (beta_out),
    .gamma_out_i(gamma_out),
    .pending_o  (pending),
    .fails_o    (fails)
  );

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(30, 80);
  endfunction

  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else begin
      stall_left <= ($urandom_range(0, 2) == 0) ? gap_len() : 0;
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("barycentric_clamp_renormalize: mismatch");
      $finish;
    end
  end

  task automatic send_item(input logic signed [IN_W-1:0] a, input logic signed [IN_W-1:0] b);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    alpha_in <= a;
    beta_in <= b;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic write_eps(input logic [DATA_W-1:0] value);
    drain();
    repeat (12) @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= EPS_ADDR;
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic send_random();
    int mode;
    int a;
    int b;
    mode = $urandom_range(0, 9);
    if (mode < 5) begin
      a = $urandom_range(0, ONE_INT);
      b = $urandom_range(0, ONE_INT - a);
    end else if (mode < 7) begin
      a = ($urandom_range(0, 1) ? ONE_INT : 0) + int'($urandom_range(0, 600)) - 300;
      b = ($urandom_range(0, 1) ? ONE_INT : 0) + int'($urandom_range(0, 600)) - 300;
    end else if (mode == 7) begin
      a = int'($urandom_range(0, 200000)) - 70000;
      b = $urandom_range(0, 1) ? a : ONE_INT - 2 * a;
    end else begin
      a = $urandom;
      b = $urandom;
    end
    send_item(IN_W'(a), IN_W'(b));
  endtask

  initial begin
    automatic int dir_a[16] = '{-524288, 524287, -524288, 524287, 0, 65536, 0, 21845,
                                10000, 20000, 40000, 1, 66, -1, 32768, 30000};
    automatic int dir_b[16] = '{-524288, 524287, 524287, -524288, 0, 0, 65536, 21845,
                                10000, 25536, 12768, 1, 66, -1, 32768, 30000};
    automatic int eps_plan[7] = '{1, 21845, 0, 32767, 21846, 0, 66};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int i = 0; i < 16; i++) send_item(IN_W'(dir_a[i]), IN_W'(dir_b[i]));
    for (int phase = 0; phase < 8; phase++) begin
      if (phase > 0) begin
        if (phase == 5) write_eps($urandom_range(1, 21845));
        else if (phase == 6) write_eps($urandom_range(0, 32767));
        else write_eps(eps_plan[phase-1]);
      end
      quiet <= ($urandom_range(0, 3) == 0);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (phase == 2 && n == PHASE_ITEMS / 2) drain();
        send_random();
      end
    end
    drain();
    repeat (20) @(posedge clk_i);
    if (fails == 0) begin
      $display("barycentric_clamp_renormalize: match");
    end else begin
      $display("barycentric_clamp_renormalize: mismatch");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/bcr_pkg.sv
hw/rtl/bcr_cfg.sv
hw/rtl/bcr_sort.sv
hw/rtl/bcr_clamp.sv
hw/rtl/bcr_div.sv
hw/rtl/barycentric_clamp_renormalize.sv
tb/sv/bcr_weight_checker.sv
tb/sv/barycentric_clamp_renormalize_tb.sv
